// ===== hdl/rfr_pkg.sv =====
`default_nettype none
package rfr_pkg;

   // frame geometry
   localparam int SHORT_FRAME_LEN = 10;
   localparam int LONG_FRAME_LEN  = 32;
   localparam int INDEX_W         = 6;
   localparam int HEAD_BYTES      = 8;
   localparam int STICK_W         = 48;

   localparam logic [INDEX_W-1:0] SHORT_LAST = INDEX_W'(SHORT_FRAME_LEN - 1);
   localparam logic [INDEX_W-1:0] LONG_LAST  = INDEX_W'(LONG_FRAME_LEN - 1);

   localparam logic [7:0] SYNC_BYTE = 8'h55;

   // control register map (word index)
   localparam logic REG_SHORT_FRAMES = 1'b0;

   // frame status codes
   localparam logic [1:0] STATUS_CONTROL  = 2'd0;
   localparam logic [1:0] STATUS_COMMAND  = 2'd1;
   localparam logic [1:0] STATUS_LONG     = 2'd2;
   localparam logic [1:0] STATUS_MISMATCH = 2'd3;

   // sd command codes
   localparam logic [2:0] SD_NONE       = 3'd0;
   localparam logic [2:0] SD_INFO_QUERY = 3'd1;
   localparam logic [2:0] SD_INFO_UP    = 3'd2;
   localparam logic [2:0] SD_INFO_MIN   = 3'd3;
   localparam logic [2:0] SD_DATA_QUERY = 3'd4;
   localparam logic [2:0] SD_RECORD     = 3'd5;
   localparam logic [2:0] SD_SEND       = 3'd6;

   // bit in byte 1 that marks a command frame
   localparam int CMD_FLAG_BIT = 6;

   // end of frame event from the framer
   typedef struct packed {
      logic               done;
      logic               match;
      logic               short_mode;
      logic [7:0]         byte1;
      logic [7:0]         byte2;
      logic [STICK_W-1:0] sticks;
   } frame_event_type;

   // one result item
   typedef struct packed {
      logic [1:0]         frame_status;
      logic [2:0]         sd_command;
      logic [1:0]         rocker_keys;
      logic [3:0]         dial_bits;
      logic [7:0]         pad_buttons;
      logic [STICK_W-1:0] stick_bytes;
   } result_type;

endpackage
`default_nettype wire

// ===== hdl/rfr_csr.sv =====
`default_nettype none
module rfr_csr (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output logic             short_frames
);

   logic short_frames_ff;
   logic short_frames_in;
   logic wr_en;

   // register write on the access phase
   assign wr_en = csr_psel && csr_penable && csr_pwrite &&
                  (csr_paddr[2] == rfr_pkg::REG_SHORT_FRAMES);

   always_comb begin
      short_frames_in = short_frames_ff;
      if (wr_en) begin
         short_frames_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_frames_ff <= 1'b1;
      end else begin
         short_frames_ff <= short_frames_in;
      end
   end

   // read back
   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == rfr_pkg::REG_SHORT_FRAMES) begin
         csr_prdata = {31'd0, short_frames_ff};
      end
   end

   assign csr_pready   = 1'b1;
   assign short_frames = short_frames_ff;

endmodule
`default_nettype wire

// ===== hdl/rfr_framer.sv =====
`default_nettype none
module rfr_framer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] rx_byte,
   input  wire logic       short_frames,
   output rfr_pkg::frame_event_type frame_event
);

   logic [rfr_pkg::INDEX_W-1:0] index_ff;
   logic [rfr_pkg::INDEX_W-1:0] index_in;
   logic [7:0]                  sum_ff;
   logic [7:0]                  sum_in;
   logic [7:0]                  head_ff [rfr_pkg::HEAD_BYTES];
   logic [rfr_pkg::INDEX_W-1:0] last;
   logic                        in_body;
   logic                        at_end;

   assign last = short_frames ? rfr_pkg::SHORT_LAST : rfr_pkg::LONG_LAST;

   // position tracking and running sum
   always_comb begin
      index_in = index_ff;
      sum_in   = sum_ff;
      in_body  = 1'b0;
      at_end   = 1'b0;
      if (index_ff == '0) begin
         if (rx_byte == rfr_pkg::SYNC_BYTE) begin
            sum_in   = rx_byte;
            index_in = rfr_pkg::INDEX_W'(1);
         end
      end else if (index_ff < last) begin
         in_body  = 1'b1;
         sum_in   = sum_ff + rx_byte;
         index_in = index_ff + rfr_pkg::INDEX_W'(1);
      end else begin
         // checksum byte, or past it after a mode change
         at_end   = (index_ff == last);
         index_in = '0;
         sum_in   = 8'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff <= '0;
         sum_ff   <= 8'd0;
      end else if (step) begin
         index_ff <= index_in;
         sum_ff   <= sum_in;
      end
   end

   // frame bytes 1 to 8, each in a slot of its own
   always_ff @(posedge clock) begin
      for (int k = 0; k < rfr_pkg::HEAD_BYTES; k++) begin
         if (step && in_body && (index_ff == rfr_pkg::INDEX_W'(k + 1))) begin
            head_ff[k] <= rx_byte;
         end
      end
   end

   // end of frame report
   always_comb begin
      frame_event.done       = at_end;
      frame_event.match      = (rx_byte == sum_ff);
      frame_event.short_mode = short_frames;
      frame_event.byte1      = head_ff[0];
      frame_event.byte2      = head_ff[1];
      frame_event.sticks     = {head_ff[7], head_ff[6], head_ff[5],
                                head_ff[4], head_ff[3], head_ff[2]};
   end

endmodule
`default_nettype wire

// ===== hdl/rfr_hold.sv =====
`default_nettype none
module rfr_hold (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire rfr_pkg::frame_event_type frame_event,
   output rfr_pkg::result_type          result
);

   logic [2:0]  cmd_ff;
   logic [2:0]  cmd_in;
   logic [61:0] ctrl_ff;
   logic [61:0] ctrl_in;
   logic [1:0]  status;
   logic        good_short;

   assign good_short = frame_event.match && frame_event.short_mode;

   // decode a good short frame into command or control values
   always_comb begin
      cmd_in  = cmd_ff;
      ctrl_in = ctrl_ff;
      status  = rfr_pkg::STATUS_MISMATCH;
      if (good_short) begin
         if (frame_event.byte1[rfr_pkg::CMD_FLAG_BIT]) begin
            status = rfr_pkg::STATUS_COMMAND;
            if ((frame_event.byte2 >= {5'd0, rfr_pkg::SD_INFO_QUERY}) &&
                (frame_event.byte2 <= {5'd0, rfr_pkg::SD_SEND})) begin
               cmd_in = frame_event.byte2[2:0];
            end else begin
               cmd_in = rfr_pkg::SD_NONE;
            end
         end else begin
            status  = rfr_pkg::STATUS_CONTROL;
            ctrl_in = {frame_event.byte1[5:4], frame_event.byte1[3:0],
                       frame_event.byte2, frame_event.sticks};
         end
      end else if (frame_event.match) begin
         status = rfr_pkg::STATUS_LONG;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff  <= rfr_pkg::SD_NONE;
         ctrl_ff <= 62'd0;
      end else if (step && frame_event.done) begin
         cmd_ff  <= cmd_in;
         ctrl_ff <= ctrl_in;
      end
   end

   // result fields carry the values as updated by this frame
   always_comb begin
      result.frame_status = status;
      result.sd_command   = cmd_in;
      result.rocker_keys  = ctrl_in[61:60];
      result.dial_bits    = ctrl_in[59:56];
      result.pad_buttons  = ctrl_in[55:48];
      result.stick_bytes  = ctrl_in[47:0];
   end

endmodule
`default_nettype wire

// ===== hdl/remote_frame_receiver_top.sv =====
// Remote frame receiver.
// Input channel (req_): one received radio byte per transfer. The block hunts
// for the sync byte 0x55, collects a frame of 10 bytes (short mode) or 32
// bytes (long mode) and checks the last byte against the 8-bit sum of the
// bytes before it. Good short frames are decoded into an sd command or into
// control values (rocker keys, dial bits, pad buttons, stick bytes), which
// are held between frames.
// Result channel (rsp_): one transfer at each frame end with the status and
// the held values; other bytes give no result.
// Control port (csr_): register 0 bit 0 selects short frames (reset 1). Write
// it only while no byte is in flight.
// Path: a byte accepted into the input register passes the decode into the
// result register and so onto rsp_. Throughput: one byte per cycle while no
// result is stalled, since the whole decode is one combinational pass between
// the input register and the result register.
// A stalled result holds; the input register still takes one more byte, and
// req_stall rises only when both registers are full and rsp_stall is high.
// Reset (synchronous) clears the frame position, running sum, held values
// and both valid flags, and sets short mode.
`default_nettype none
module remote_frame_receiver_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_frame_status,
   output logic [2:0]       rsp_sd_command,
   output logic [1:0]       rsp_rocker_keys,
   output logic [3:0]       rsp_dial_bits,
   output logic [7:0]       rsp_pad_buttons,
   output logic [47:0]      rsp_stick_bytes,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   logic                      short_frames;
   logic                      in_valid_ff;
   logic                      in_valid_in;
   logic [7:0]                in_byte_ff;
   logic                      out_valid_ff;
   logic                      out_valid_in;
   rfr_pkg::result_type       out_ff;
   rfr_pkg::result_type       result;
   rfr_pkg::frame_event_type  frame_event;
   logic                      req_take;
   logic                      advance;

   // control register
   rfr_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .short_frames (short_frames)
   );

   // pipeline flow control
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = frame_event.done;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // frame collection
   rfr_framer u_framer (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .rx_byte      (in_byte_ff),
      .short_frames (short_frames),
      .frame_event  (frame_event)
   );

   // decode and held values
   rfr_hold u_hold (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .frame_event (frame_event),
      .result      (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (advance && frame_event.done) begin
         out_ff <= result;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_frame_status = out_ff.frame_status;
   assign rsp_sd_command   = out_ff.sd_command;
   assign rsp_rocker_keys  = out_ff.rocker_keys;
   assign rsp_dial_bits    = out_ff.dial_bits;
   assign rsp_pad_buttons  = out_ff.pad_buttons;
   assign rsp_stick_bytes  = out_ff.stick_bytes;

   // a new result only follows a processed byte
   a_rsp_from_advance : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(advance))
      else $error("result appeared without a processed byte");

   // result fields change only when a byte is processed
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(rsp_frame_status) && $stable(rsp_stick_bytes) &&
                    $stable(rsp_sd_command)))
      else $error("result fields changed without a processed byte");

   // a full pipeline against a stalled receiver pushes back
   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall && in_valid_ff) |-> req_stall)
      else $error("input taken while both registers are full");

endmodule
`default_nettype wire
